FILE: src/tps_pkg.sv
// Shared types, codes and lookup functions of the timed phase sequencer.
// No dependencies; every other file of the block refers to this package.
package tps_pkg;

	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int HALF_W     = 16;
	localparam int COUNT_W    = 16;
	localparam int EDGE_IDX_W = 2;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_RESTART = 2'd1,
		ACT_FORCE   = 2'd2,
		ACT_CUE     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_FITTING    = 2'd1,
		PH_TRANSITION = 2'd2,
		PH_ROOTS      = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		CAUSE_NONE    = 3'd0,
		CAUSE_RESTART = 3'd1,
		CAUSE_FORCED  = 3'd2,
		CAUSE_CUE     = 3'd3,
		CAUSE_EDGE    = 3'd4,
		CAUSE_TIMEOUT = 3'd5
	} cause_t;

	typedef enum logic [2:0] {
		EV_NONE          = 3'd0,
		EV_FACE_PRESENT  = 3'd1,
		EV_FACE_ABSENT   = 3'd2,
		EV_FIT_CONVERGED = 3'd3,
		EV_SCENE_DONE    = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		REG_MIN_DWELL_IF = 3'd0,
		REG_MIN_DWELL_TR = 3'd1,
		REG_MAX_TIME_IF  = 3'd2,
		REG_MAX_TIME_TR  = 3'd3,
		REG_HOLD_IDLE    = 3'd4,
		REG_HOLD_FITTING = 3'd5,
		REG_HOLD_DONE_RT = 3'd6
	} reg_idx_t;

	localparam logic [DATA_W-1:0] RST_MIN_DWELL_IF = 32'd131080000;
	localparam logic [DATA_W-1:0] RST_MIN_DWELL_TR = 32'd2621440000;
	localparam logic [DATA_W-1:0] RST_MAX_TIME_IF  = 32'd1966080000;
	localparam logic [DATA_W-1:0] RST_MAX_TIME_TR  = 32'd12000;
	localparam logic [HALF_W-1:0] RST_HOLD_IDLE    = 16'd1500;
	localparam logic [DATA_W-1:0] RST_HOLD_FITTING = 32'd163841500;
	localparam logic [DATA_W-1:0] RST_HOLD_DONE_RT = 32'd524288000;

	typedef struct packed {
		logic [DATA_W-1:0] min_dwell_idle_fitting;
		logic [DATA_W-1:0] min_dwell_transition_roots;
		logic [DATA_W-1:0] max_time_idle_fitting;
		logic [DATA_W-1:0] max_time_transition_roots;
		logic [HALF_W-1:0] hold_idle_presence;
		logic [DATA_W-1:0] hold_fitting_edges;
		logic [DATA_W-1:0] hold_done_and_roots;
	} cfg_t;

	typedef struct packed {
		action_t           action;
		logic [HALF_W-1:0] elapsed_ticks;
		phase_t            target_phase;
		logic              person_seen;
		logic              fit_locked;
		logic              scene_done_report;
	} item_t;

	typedef struct packed {
		phase_t             phase;
		logic               entered;
		cause_t             cause;
		event_t             fired_event;
		logic [HALF_W-1:0]  phase_time;
		logic [COUNT_W-1:0] entry_count;
	} res_t;

	function automatic logic [HALF_W-1:0] half_of(logic [DATA_W-1:0] r, logic hi);
		return hi ? r[DATA_W-1:HALF_W] : r[HALF_W-1:0];
	endfunction

	function automatic logic [2:0] edges_in(phase_t p);
		return (p == PH_FITTING) ? 3'd2 : 3'd1;
	endfunction

	function automatic event_t edge_event(phase_t p, logic [EDGE_IDX_W-1:0] e);
		event_t ev;
		ev = EV_NONE;
		unique case (p)
			PH_IDLE:       ev = (e == '0) ? EV_FACE_PRESENT : EV_NONE;
			PH_FITTING:    ev = (e == '0) ? EV_FIT_CONVERGED :
			                    (e == 2'd1) ? EV_FACE_ABSENT : EV_NONE;
			PH_TRANSITION: ev = (e == '0) ? EV_SCENE_DONE : EV_NONE;
			PH_ROOTS:      ev = (e == '0) ? EV_FACE_ABSENT : EV_NONE;
			default:       ev = EV_NONE;
		endcase
		return ev;
	endfunction

	function automatic phase_t edge_target(phase_t p, logic [EDGE_IDX_W-1:0] e);
		phase_t t;
		t = PH_IDLE;
		if (e == '0) begin
			unique case (p)
				PH_IDLE:       t = PH_FITTING;
				PH_FITTING:    t = PH_TRANSITION;
				PH_TRANSITION: t = PH_ROOTS;
				default:       t = PH_IDLE;
			endcase
		end
		return t;
	endfunction

	function automatic phase_t timeout_target(phase_t p);
		return (p == PH_TRANSITION) ? PH_ROOTS : PH_IDLE;
	endfunction

	function automatic logic level_of(event_t ev, logic face, logic fit, logic done);
		logic l;
		case (ev)
			EV_FACE_PRESENT:  l = face;
			EV_FACE_ABSENT:   l = ~face;
			EV_FIT_CONVERGED: l = fit;
			EV_SCENE_DONE:    l = done;
			default:          l = 1'b0;
		endcase
		return l;
	endfunction

	function automatic logic [HALF_W-1:0] min_dwell(cfg_t c, phase_t p);
		return half_of(p[1] ? c.min_dwell_transition_roots : c.min_dwell_idle_fitting, p[0]);
	endfunction

	function automatic logic [HALF_W-1:0] timeout_ticks(cfg_t c, phase_t p);
		return half_of(p[1] ? c.max_time_transition_roots : c.max_time_idle_fitting, p[0]);
	endfunction

	function automatic logic [HALF_W-1:0] hold_time(cfg_t c, phase_t p,
			logic [EDGE_IDX_W-1:0] e);
		logic [HALF_W-1:0] h;
		unique case (p)
			PH_IDLE:       h = c.hold_idle_presence;
			PH_FITTING:    h = half_of(c.hold_fitting_edges, e != '0);
			PH_TRANSITION: h = half_of(c.hold_done_and_roots, 1'b0);
			default:       h = half_of(c.hold_done_and_roots, 1'b1);
		endcase
		return h;
	endfunction

endpackage

FILE: src/tps_if.sv
// Valid/ready channel interfaces for sequencer items and results.
// Depends on tps_pkg for the payload types.
interface tps_item_if;
	logic                        valid;
	logic                        ready;
	tps_pkg::action_t            action;
	logic [tps_pkg::HALF_W-1:0]  elapsed_ticks;
	tps_pkg::phase_t             target_phase;
	logic                        person_seen;
	logic                        fit_locked;
	logic                        scene_done_report;

	modport source (output valid, action, elapsed_ticks, target_phase, person_seen,
		fit_locked, scene_done_report, input ready);
	modport sink (input valid, action, elapsed_ticks, target_phase, person_seen,
		fit_locked, scene_done_report, output ready);
endinterface

interface tps_result_if;
	logic                        valid;
	logic                        ready;
	tps_pkg::phase_t             phase;
	logic                        entered;
	tps_pkg::cause_t             cause;
	tps_pkg::event_t             fired_event;
	logic [tps_pkg::HALF_W-1:0]  phase_time;
	logic [tps_pkg::COUNT_W-1:0] entry_count;

	modport source (output valid, phase, entered, cause, fired_event, phase_time,
		entry_count, input ready);
	modport sink (input valid, phase, entered, cause, fired_event, phase_time,
		entry_count, output ready);
endinterface

FILE: src/tps_cfg.sv
// APB-style register file holding the sequencer timings.
// Depends on tps_pkg for cfg_t, register indexes and reset values.
module tps_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tps_pkg::ADDR_W-1:0]  paddr,
	input  logic [tps_pkg::DATA_W-1:0]  pwdata,
	output logic [tps_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output tps_pkg::cfg_t               cfg
);

	tps_pkg::cfg_t     cfg_q;
	tps_pkg::reg_idx_t idx;
	logic              wr;

	assign pready = 1'b1;
	assign idx    = tps_pkg::reg_idx_t'(paddr[tps_pkg::ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_dwell_idle_fitting     <= tps_pkg::RST_MIN_DWELL_IF;
			cfg_q.min_dwell_transition_roots <= tps_pkg::RST_MIN_DWELL_TR;
			cfg_q.max_time_idle_fitting      <= tps_pkg::RST_MAX_TIME_IF;
			cfg_q.max_time_transition_roots  <= tps_pkg::RST_MAX_TIME_TR;
			cfg_q.hold_idle_presence         <= tps_pkg::RST_HOLD_IDLE;
			cfg_q.hold_fitting_edges         <= tps_pkg::RST_HOLD_FITTING;
			cfg_q.hold_done_and_roots        <= tps_pkg::RST_HOLD_DONE_RT;
		end else if (wr) begin
			unique case (idx)
				tps_pkg::REG_MIN_DWELL_IF: cfg_q.min_dwell_idle_fitting <= pwdata;
				tps_pkg::REG_MIN_DWELL_TR: cfg_q.min_dwell_transition_roots <= pwdata;
				tps_pkg::REG_MAX_TIME_IF:  cfg_q.max_time_idle_fitting <= pwdata;
				tps_pkg::REG_MAX_TIME_TR:  cfg_q.max_time_transition_roots <= pwdata;
				tps_pkg::REG_HOLD_IDLE:    cfg_q.hold_idle_presence <= pwdata[tps_pkg::HALF_W-1:0];
				tps_pkg::REG_HOLD_FITTING: cfg_q.hold_fitting_edges <= pwdata;
				tps_pkg::REG_HOLD_DONE_RT: cfg_q.hold_done_and_roots <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tps_pkg::REG_MIN_DWELL_IF: prdata = cfg_q.min_dwell_idle_fitting;
			tps_pkg::REG_MIN_DWELL_TR: prdata = cfg_q.min_dwell_transition_roots;
			tps_pkg::REG_MAX_TIME_IF:  prdata = cfg_q.max_time_idle_fitting;
			tps_pkg::REG_MAX_TIME_TR:  prdata = cfg_q.max_time_transition_roots;
			tps_pkg::REG_HOLD_IDLE:    prdata = 32'(cfg_q.hold_idle_presence);
			tps_pkg::REG_HOLD_FITTING: prdata = cfg_q.hold_fitting_edges;
			tps_pkg::REG_HOLD_DONE_RT: prdata = cfg_q.hold_done_and_roots;
			default:                   prdata = '0;
		endcase
	end

endmodule

FILE: src/tps_core.sv
// Phase state registers and the combinational next-state logic of one item.
// Depends on tps_pkg for item, config and result types and edge tables.
module tps_core #(
	parameter int TIME_BITS       = 16,
	parameter int EDGES_PER_PHASE = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  tps_pkg::item_t item,
	input  tps_pkg::cfg_t  cfg,
	output tps_pkg::res_t  res
);

	localparam int TW = TIME_BITS;
	localparam int CW = (TW > tps_pkg::HALF_W) ? TW : tps_pkg::HALF_W;
	localparam int SW = CW + 1;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};

	function automatic logic [TW-1:0] sat_add(logic [TW-1:0] a,
			logic [tps_pkg::HALF_W-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		return (s > SW'(TMAX)) ? TMAX : TW'(s);
	endfunction

	tps_pkg::phase_t              phase_q;
	logic [TW-1:0]                clock_q;
	logic [TW-1:0]                held_q [EDGES_PER_PHASE];
	logic                         latch_q;
	logic [tps_pkg::COUNT_W-1:0]  entries_q;

	tps_pkg::phase_t              phase_n;
	logic [TW-1:0]                clock_n;
	logic [TW-1:0]                held_n [EDGES_PER_PHASE];
	logic                         latch_n;
	logic [tps_pkg::COUNT_W-1:0]  entries_n;

	logic                         latch_t;
	logic [TW-1:0]                clock_t;
	logic                         dwell_ok;
	logic                         tested [EDGES_PER_PHASE];
	tps_pkg::event_t              ev [EDGES_PER_PHASE];
	logic                         lvl [EDGES_PER_PHASE];
	logic [TW-1:0]                held_t [EDGES_PER_PHASE];
	logic                         pass [EDGES_PER_PHASE];
	logic                         fire;
	tps_pkg::event_t              fire_ev;
	tps_pkg::phase_t              fire_tgt;
	logic                         timeout;
	logic [tps_pkg::HALF_W-1:0]   mx;
	logic                         enter;
	tps_pkg::cause_t              cause;

	// Edge and timeout evaluation for a tick: latch the scene report first, then test edges.
	always_comb begin
		latch_t  = latch_q | item.scene_done_report;
		clock_t  = sat_add(clock_q, item.elapsed_ticks);
		dwell_ok = CW'(clock_t) >= CW'(tps_pkg::min_dwell(cfg, phase_q));
		for (int i = 0; i < EDGES_PER_PHASE; i++) begin
			tested[i] = 3'(i) < tps_pkg::edges_in(phase_q);
			ev[i]     = tested[i] ? tps_pkg::edge_event(phase_q, 2'(i)) : tps_pkg::EV_NONE;
			lvl[i]    = tps_pkg::level_of(ev[i], item.person_seen, item.fit_locked,
				latch_t);
			held_t[i] = lvl[i] ? sat_add(held_q[i], item.elapsed_ticks) : '0;
			pass[i]   = tested[i] && lvl[i]
				&& (CW'(held_t[i]) >= CW'(tps_pkg::hold_time(cfg, phase_q, 2'(i))))
				&& (dwell_ok || ev[i] == tps_pkg::EV_SCENE_DONE);
		end
		fire     = 1'b0;
		fire_ev  = tps_pkg::EV_NONE;
		fire_tgt = tps_pkg::PH_IDLE;
		for (int i = EDGES_PER_PHASE - 1; i >= 0; i--) begin
			if (pass[i]) begin
				fire     = 1'b1;
				fire_ev  = ev[i];
				fire_tgt = tps_pkg::edge_target(phase_q, 2'(i));
			end
		end
		mx      = tps_pkg::timeout_ticks(cfg, phase_q);
		timeout = (mx != '0) && (CW'(clock_t) >= CW'(mx));
	end

	always_comb begin
		enter   = 1'b1;
		phase_n = phase_q;
		cause   = tps_pkg::CAUSE_NONE;
		res.fired_event = tps_pkg::EV_NONE;
		unique case (item.action)
			tps_pkg::ACT_RESTART: begin
				phase_n = tps_pkg::PH_IDLE;
				cause   = tps_pkg::CAUSE_RESTART;
			end
			tps_pkg::ACT_FORCE: begin
				phase_n = item.target_phase;
				cause   = tps_pkg::CAUSE_FORCED;
			end
			tps_pkg::ACT_CUE: begin
				phase_n = tps_pkg::edge_target(phase_q, '0);
				cause   = tps_pkg::CAUSE_CUE;
			end
			default: begin
				if (fire) begin
					phase_n         = fire_tgt;
					cause           = tps_pkg::CAUSE_EDGE;
					res.fired_event = fire_ev;
				end else if (timeout) begin
					phase_n = tps_pkg::timeout_target(phase_q);
					cause   = tps_pkg::CAUSE_TIMEOUT;
				end else begin
					enter = 1'b0;
				end
			end
		endcase

		// Only a tick can stay in place, so the tick values are the hold values.
		clock_n   = enter ? '0 : clock_t;
		latch_n   = enter ? 1'b0 : latch_t;
		entries_n = entries_q + tps_pkg::COUNT_W'(enter);
		for (int i = 0; i < EDGES_PER_PHASE; i++)
			held_n[i] = enter ? '0 : (tested[i] ? held_t[i] : held_q[i]);

		res.phase       = phase_n;
		res.entered     = enter;
		res.cause       = cause;
		res.phase_time  = tps_pkg::HALF_W'(clock_n);
		res.entry_count = entries_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tps_pkg::PH_IDLE;
			clock_q   <= '0;
			latch_q   <= 1'b0;
			entries_q <= '0;
			for (int i = 0; i < EDGES_PER_PHASE; i++)
				held_q[i] <= '0;
		end else if (en) begin
			phase_q   <= phase_n;
			clock_q   <= clock_n;
			latch_q   <= latch_n;
			entries_q <= entries_n;
			for (int i = 0; i < EDGES_PER_PHASE; i++)
				held_q[i] <= held_n[i];
		end
	end

	a_entry_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.entered |=> clock_q == '0 && !latch_q)
		else $error("phase entry did not clear clock and latch");

	a_stay_keeps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		en && !res.entered |=> phase_q == $past(phase_q))
		else $error("phase changed without an entry");

	a_entry_counted: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.entered |=> entries_q == tps_pkg::COUNT_W'($past(entries_q) + 1'b1))
		else $error("entry not counted");

	a_event_only_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		en |-> (res.cause == tps_pkg::CAUSE_EDGE) == (res.fired_event != tps_pkg::EV_NONE))
		else $error("fired event and cause disagree");

endmodule

FILE: src/timed_phase_sequencer.sv
// Top level of the timed phase sequencer: item register, core, result register.
// Depends on tps_pkg, tps_if (channel interfaces), tps_cfg and tps_core.
//
//   port      kind         dir   beat
//   item      valid/ready  in    one action with elapsed time and signal levels
//   result    valid/ready  out   phase, entry flag, cause, event, clock, entry count
//   apb       psel/penable in    timing register writes and reads, zero wait
//
// One beat per cycle sustained while results are taken; a result passes the item
// register, then the result register, before it is offered and can leave.
// The rate is set by the loop from the phase state registers through the edge
// test, one saturating add and compare per edge, back into those registers.
// Reset clears the phase to idle, all counters and the scene latch, and loads
// the default timings; no clearing pass follows.
// A stalled result holds in its register; an empty item register still takes one
// more beat, then item.ready drops until the result drains.
module timed_phase_sequencer #(
	parameter int TIME_BITS       = 16,
	parameter int EDGES_PER_PHASE = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tps_item_if.sink                    item,
	tps_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tps_pkg::ADDR_W-1:0]  paddr,
	input  logic [tps_pkg::DATA_W-1:0]  pwdata,
	output logic [tps_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	tps_pkg::cfg_t  cfg;
	tps_pkg::item_t item_s1;
	logic           item_valid_s1;
	tps_pkg::res_t  res;
	tps_pkg::res_t  res_q;
	logic           res_valid_q;
	logic           adv;

	// Advance the item stage whenever the result register is free or draining.
	assign adv        = item_valid_s1 & (~res_valid_q | result.ready);
	assign item.ready = ~item_valid_s1 | adv;

	tps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tps_core #(
		.TIME_BITS       (TIME_BITS),
		.EDGES_PER_PHASE (EDGES_PER_PHASE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (item.ready)
				item_valid_s1 <= item.valid;
			if (adv)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	// Capture the incoming beat.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action            <= item.action;
			item_s1.elapsed_ticks     <= item.elapsed_ticks;
			item_s1.target_phase      <= item.target_phase;
			item_s1.person_seen       <= item.person_seen;
			item_s1.fit_locked        <= item.fit_locked;
			item_s1.scene_done_report <= item.scene_done_report;
		end
	end

	// Hold the result until taken; load the next one as the item advances.
	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res;
	end

	assign result.valid       = res_valid_q;
	assign result.phase       = res_q.phase;
	assign result.entered     = res_q.entered;
	assign result.cause       = res_q.cause;
	assign result.fired_event = res_q.fired_event;
	assign result.phase_time  = res_q.phase_time;
	assign result.entry_count = res_q.entry_count;

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready && item_valid_s1 |-> !item.ready && !adv)
		else $error("item taken while both stages are blocked");

endmodule
